// File: hdl/csts_pkg.sv
// Shared types, codes and helpers for the cyclic slot task scheduler.
// No dependencies; imported by every module of the block but the stamp memory.
package csts_pkg;

  // Item kinds on the request channel
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // Slot code for an empty slot
  localparam logic [1:0] SLOT_EMPTY = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_SLOT_TABLE  = 3'd0;
  localparam logic [2:0] CFG_CLASS0_SIZE = 3'd1;
  localparam logic [2:0] CFG_CLASS1_SIZE = 3'd2;
  localparam logic [2:0] CFG_CLASS2_SIZE = 3'd3;
  localparam logic [2:0] CFG_NEEDS_WORK  = 3'd4;

  // Configuration reset values
  localparam logic [19:0] SLOT_TABLE_RST  = 20'd937268;
  localparam logic [6:0]  CLASS0_SIZE_RST = 7'd3;
  localparam logic [6:0]  CLASS1_SIZE_RST = 7'd15;
  localparam logic [6:0]  CLASS2_SIZE_RST = 7'd20;
  localparam logic [63:0] NEEDS_WORK_RST  = 64'd34359738367;

  typedef enum logic [2:0] {
    OC_IDLE     = 3'd0,
    OC_FILLER   = 3'd1,
    OC_NOTREADY = 3'd2,
    OC_DISPATCH = 3'd3,
    OC_EXTENDED = 3'd4,
    OC_CHANGE   = 3'd5,
    OC_DONE     = 3'd6,
    OC_INVALID  = 3'd7
  } outcome_t;

  // Result of one request, less the reaction time
  typedef struct packed {
    outcome_t   outcome;
    logic [5:0] task_id;
    logic       interrupted;
    logic [5:0] interrupted_id;
    logic       overrun;
    logic       need_reaction;
  } res_t;

  // Class size as used: zero counts as one, anything above 64 as 64
  function automatic logic [6:0] eff_size(input logic [6:0] s);
    logic [6:0] r;
    r = s;
    if (s == 7'd0) r = 7'd1;
    else if (s > 7'd64) r = 7'd64;
    return r;
  endfunction

endpackage

// File: hdl/csts_stamp_ram.sv
// Change-stamp memory: one write port, one registered read port.
// Uses no package.
module csts_stamp_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/csts_core.sv
// Scheduler state, configuration registers and per-request decision logic.
// Depends on csts_pkg; drives the stamp memory ports.
module csts_core
  import csts_pkg::*;
#(
  parameter int SLOTS  = 10,
  parameter int TASKS  = 64,
  parameter int WINDOW = 10,
  parameter int TW     = $clog2(TASKS),
  parameter int SPW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int WPW    = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          accept,
  input  logic [1:0]    kind,
  input  logic [5:0]    task_index,
  output res_t          res,
  output logic          stamp_we,
  output logic [TW-1:0] stamp_waddr,
  output logic          stamp_re,
  output logic [TW-1:0] stamp_raddr
);

  // Configuration
  logic [19:0] slot_table;
  logic [6:0]  class_size [3];
  logic [63:0] needs_work_mask;

  // State
  logic [TASKS-1:0]  ready_flags, ready_flags_next;
  logic [5:0]        class_pointer [3];
  logic [5:0]        class_pointer_next [3];
  logic [SPW-1:0]    slot_pointer, slot_pointer_next;
  logic [WINDOW-1:0] extension_window, extension_window_next;
  logic [WPW-1:0]    window_pointer, window_pointer_next;
  logic [5:0]        running_task, running_task_next;
  logic              task_active, task_active_next;
  logic              second_period, second_period_next;

  // Tick path
  logic [31:0] slot_ext;
  logic [1:0]  code;
  logic [6:0]  sz0, sz1, sz2, size;
  logic [7:0]  base;
  logic [5:0]  ptr_raw, ptr;
  logic [6:0]  ptr_inc;
  logic [5:0]  ptr_wrap;
  logic [8:0]  id;
  logic        id_ok;
  logic        tidx_ok;
  logic        extend;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_table      <= SLOT_TABLE_RST;
      class_size[0]   <= CLASS0_SIZE_RST;
      class_size[1]   <= CLASS1_SIZE_RST;
      class_size[2]   <= CLASS2_SIZE_RST;
      needs_work_mask <= NEEDS_WORK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOT_TABLE:  slot_table      <= cfg_data[19:0];
        CFG_CLASS0_SIZE: class_size[0]   <= cfg_data[6:0];
        CFG_CLASS1_SIZE: class_size[1]   <= cfg_data[6:0];
        CFG_CLASS2_SIZE: class_size[2]   <= cfg_data[6:0];
        CFG_NEEDS_WORK:  needs_work_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    slot_ext = {12'd0, slot_table};
    code     = slot_ext[{slot_pointer, 1'b0} +: 2];
    sz0      = eff_size(class_size[0]);
    sz1      = eff_size(class_size[1]);
    sz2      = eff_size(class_size[2]);
    case (code)
      2'd0: begin
        base    = 8'd0;
        size    = sz0;
        ptr_raw = class_pointer[0];
      end
      2'd1: begin
        base    = {1'b0, sz0};
        size    = sz1;
        ptr_raw = class_pointer[1];
      end
      2'd2: begin
        base    = 8'({1'b0, sz0} + {1'b0, sz1});
        size    = sz2;
        ptr_raw = class_pointer[2];
      end
      default: begin
        base    = 8'd0;
        size    = 7'd1;
        ptr_raw = 6'd0;
      end
    endcase
    // stale pointer after a resize restarts at zero
    ptr      = ({1'b0, ptr_raw} >= size) ? 6'd0 : ptr_raw;
    ptr_inc  = {1'b0, ptr} + 7'd1;
    ptr_wrap = (ptr_inc == size) ? 6'd0 : ptr_inc[5:0];
    id       = {1'b0, base} + {3'd0, ptr};
    id_ok    = id < 9'(TASKS);
    tidx_ok  = {1'b0, task_index} < 7'(TASKS);
    extend   = task_active && !second_period && !(|extension_window);
  end

  always_comb begin
    res                   = '0;
    res.outcome           = OC_INVALID;
    ready_flags_next      = ready_flags;
    class_pointer_next    = class_pointer;
    slot_pointer_next     = slot_pointer;
    extension_window_next = extension_window;
    window_pointer_next   = window_pointer;
    running_task_next     = running_task;
    task_active_next      = task_active;
    second_period_next    = second_period;
    stamp_we              = 1'b0;
    stamp_waddr           = task_index[TW-1:0];
    stamp_re              = 1'b0;
    stamp_raddr           = id[TW-1:0];

    case (kind)
      KIND_CHANGE: begin
        if (tidx_ok) begin
          res.overrun                          = ready_flags[task_index[TW-1:0]];
          ready_flags_next[task_index[TW-1:0]] = 1'b1;
          res.outcome                          = OC_CHANGE;
          res.task_id                          = task_index;
          stamp_we                             = accept;
        end
      end
      KIND_DONE: begin
        if (task_active) begin
          ready_flags_next[running_task[TW-1:0]] = 1'b0;
          task_active_next                       = 1'b0;
          res.outcome                            = OC_DONE;
          res.task_id                            = running_task;
        end
      end
      KIND_TICK: begin
        extension_window_next[window_pointer] = extend;
        window_pointer_next = (window_pointer == WPW'(WINDOW - 1)) ? '0 :
                              WPW'(window_pointer + 1'b1);
        if (extend) begin
          second_period_next = 1'b1;
          res.outcome        = OC_EXTENDED;
          res.task_id        = running_task;
        end else begin
          if (task_active) begin
            res.interrupted    = 1'b1;
            res.interrupted_id = running_task;
            task_active_next   = 1'b0;
          end
          slot_pointer_next = (slot_pointer == SPW'(SLOTS - 1)) ? '0 :
                              SPW'(slot_pointer + 1'b1);
          if (code == SLOT_EMPTY) begin
            res.outcome = OC_IDLE;
          end else begin
            class_pointer_next[code] = ptr_wrap;
            if (!id_ok) begin
              res.outcome = OC_INVALID;
            end else if (!needs_work_mask[id[5:0]]) begin
              res.outcome = OC_FILLER;
              res.task_id = id[5:0];
            end else if (!ready_flags[id[TW-1:0]]) begin
              res.outcome = OC_NOTREADY;
              res.task_id = id[5:0];
            end else begin
              // a ready task always has a stamp written since reset
              res.outcome        = OC_DISPATCH;
              res.task_id        = id[5:0];
              res.need_reaction  = 1'b1;
              stamp_re           = accept;
              running_task_next  = id[5:0];
              task_active_next   = 1'b1;
              second_period_next = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flags      <= '0;
      class_pointer[0] <= '0;
      class_pointer[1] <= '0;
      class_pointer[2] <= '0;
      slot_pointer     <= '0;
      extension_window <= '0;
      window_pointer   <= '0;
      running_task     <= '0;
      task_active      <= 1'b0;
      second_period    <= 1'b0;
    end else if (accept) begin
      ready_flags      <= ready_flags_next;
      class_pointer    <= class_pointer_next;
      slot_pointer     <= slot_pointer_next;
      extension_window <= extension_window_next;
      window_pointer   <= window_pointer_next;
      running_task     <= running_task_next;
      task_active      <= task_active_next;
      second_period    <= second_period_next;
    end
  end

endmodule

// File: hdl/cyclic_slot_task_scheduler.sv
// Top level of the cyclic slot task scheduler: request/result pipeline.
// Depends on csts_pkg, csts_core and csts_stamp_ram.
//
// Takes one request (tick, input change or task done) per clock and returns
// exactly one result per request, in order. The decision is made in the cycle
// a request is accepted and held in the stage register while the dispatched
// task's change stamp is read from a registered memory; the result then moves
// on into the output register, where it can be taken. Sustained
// rate is one request per cycle while results are taken; the output register
// and the stage before it let a new request in while a result waits.
// Configuration writes take effect in the next cycle and must only be made
// while no request is in flight.
module cyclic_slot_task_scheduler
  import csts_pkg::*;
#(
  parameter int SLOTS  = 10,
  parameter int TASKS  = 64,
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  task_index,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [5:0]  task_id,
  output logic        interrupted,
  output logic [5:0]  interrupted_id,
  output logic [31:0] reaction_ms,
  output logic        overrun
);

  localparam int TW = $clog2(TASKS);

  logic          accept;
  res_t          res;
  logic          stamp_we, stamp_re;
  logic [TW-1:0] stamp_waddr, stamp_raddr;
  logic [31:0]   stamp_rdata;

  logic          s1_valid;
  res_t          s1_res;
  logic [31:0]   s1_now;
  logic          s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  csts_core #(
    .SLOTS  (SLOTS),
    .TASKS  (TASKS),
    .WINDOW (WINDOW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .kind        (kind),
    .task_index  (task_index),
    .res         (res),
    .stamp_we    (stamp_we),
    .stamp_waddr (stamp_waddr),
    .stamp_re    (stamp_re),
    .stamp_raddr (stamp_raddr)
  );

  csts_stamp_ram #(
    .DEPTH (TASKS),
    .AW    (TW)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (now_ms),
    .re    (stamp_re),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
      s1_now <= now_ms;
    end
    if (s1_adv) begin
      outcome        <= s1_res.outcome;
      task_id        <= s1_res.task_id;
      interrupted    <= s1_res.interrupted;
      interrupted_id <= s1_res.interrupted_id;
      overrun        <= s1_res.overrun;
      reaction_ms    <= s1_res.need_reaction ? (s1_now - stamp_rdata) : 32'd0;
    end
  end

endmodule

// File: hdl/csts_checker.sv
// Port-level checks for the cyclic slot task scheduler, bound to the top level.
// Depends on csts_pkg.
module csts_checker
  import csts_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  outcome,
  input logic        interrupted,
  input logic [5:0]  interrupted_id,
  input logic [31:0] reaction_ms,
  input logic        overrun
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(reaction_ms))
    else $error("stalled result changed");

  a_reaction: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome != OC_DISPATCH) |-> reaction_ms == 32'd0)
    else $error("reaction time on a non-dispatch result");

  a_intr: assert property (@(posedge clk) disable iff (rst)
    out_valid && interrupted |-> (outcome == OC_IDLE) || (outcome == OC_FILLER) ||
      (outcome == OC_NOTREADY) || (outcome == OC_DISPATCH) || (outcome == OC_INVALID))
    else $error("interruption on a result that is not a tick slot");

  a_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && (overrun || (!interrupted && interrupted_id != 6'd0)) |->
      (outcome == OC_CHANGE) && !interrupted && interrupted_id == 6'd0)
    else $error("overrun or interrupted task id out of place");

endmodule

bind cyclic_slot_task_scheduler csts_checker u_csts_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .outcome        (outcome),
  .interrupted    (interrupted),
  .interrupted_id (interrupted_id),
  .reaction_ms    (reaction_ms),
  .overrun        (overrun)
);
